@@ hdl/dccpm_pkg.sv @@
// Shared types, codes and constants of the paged-mode programming sequencer.
package dccpm_pkg;

	localparam int unsigned CvWidth   = 16;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned CodeWidth = 4;
	localparam int unsigned RegWidth  = 4;

	localparam logic [CvWidth-1:0] CvLimit   = 16'd1024;
	localparam logic [2:0]         IndexMask = 3'h7;

	localparam logic [ByteWidth-1:0] WritePrefixReset  = 8'd120;
	localparam logic [ByteWidth-1:0] VerifyPrefixReset = 8'd112;
	localparam logic [RegWidth-1:0]  PageRegReset      = 4'd6;
	localparam logic [CodeWidth-1:0] BusyCodeReset     = 4'd1;

	typedef enum logic [1:0] {
		ACT_WRITE    = 2'd0,
		ACT_VERIFY   = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_UNUSED   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_REFUSED  = 2'd0,
		KIND_START    = 2'd1,
		KIND_FINISHED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PAGE = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CFG_WRITE_PREFIX  = 2'd0,
		CFG_VERIFY_PREFIX = 2'd1,
		CFG_PAGE_REG      = 2'd2,
		CFG_BUSY_CODE     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [ByteWidth-1:0] write_prefix;
		logic [ByteWidth-1:0] verify_prefix;
		logic [RegWidth-1:0]  page_register_number;
		logic [CodeWidth-1:0] busy_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           action;
		logic [CvWidth-1:0]   cv_addr;
		logic [ByteWidth-1:0] data_byte;
		logic                 common_ready;
		logic [CodeWidth-1:0] step_result;
	} item_t;

	typedef struct packed {
		logic [1:0]           reg_index;
		logic [ByteWidth-1:0] value;
		logic                 write_op;
	} latch_t;

	typedef struct packed {
		logic                 valid;
		kind_t                kind;
		logic [ByteWidth-1:0] byte0;
		logic [ByteWidth-1:0] byte1;
		logic [ByteWidth-1:0] byte2;
		logic                 step_is_write;
		logic [CodeWidth-1:0] finish_code;
	} result_t;

endpackage

@@ hdl/dccpm_cfg_regs.sv @@
// Configuration register file of the paged-mode programming sequencer.
module dccpm_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output dccpm_pkg::cfg_t     cfg
);

	dccpm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_prefix         <= dccpm_pkg::WritePrefixReset;
			cfg_q.verify_prefix        <= dccpm_pkg::VerifyPrefixReset;
			cfg_q.page_register_number <= dccpm_pkg::PageRegReset;
			cfg_q.busy_code            <= dccpm_pkg::BusyCodeReset;
		end else if (cfg_valid) begin
			unique case (dccpm_pkg::cfg_index_t'(cfg_index))
				dccpm_pkg::CFG_WRITE_PREFIX:  cfg_q.write_prefix  <= cfg_data;
				dccpm_pkg::CFG_VERIFY_PREFIX: cfg_q.verify_prefix <= cfg_data;
				dccpm_pkg::CFG_PAGE_REG: begin
					cfg_q.page_register_number <= cfg_data[dccpm_pkg::RegWidth-1:0];
				end
				dccpm_pkg::CFG_BUSY_CODE: begin
					cfg_q.busy_code <= cfg_data[dccpm_pkg::CodeWidth-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/dccpm_step.sv @@
// Next-phase and result logic for one word of the sequencer.
module dccpm_step (
	input  dccpm_pkg::item_t    item,
	input  dccpm_pkg::cfg_t     cfg,
	input  dccpm_pkg::phase_t   phase,
	input  dccpm_pkg::latch_t   latch,
	output dccpm_pkg::phase_t   phase_next,
	output dccpm_pkg::latch_t   latch_next,
	output dccpm_pkg::result_t  result
);

	logic       is_request;
	logic       cv_ok;
	logic       phase_idle;
	logic       req_ok;
	logic [9:0] cv_m1;
	logic [7:0] page;
	logic [2:0] page_idx;
	logic [7:0] page_b0;
	logic [7:0] data_prefix;
	logic [7:0] data_b0;

	assign is_request = (item.action == dccpm_pkg::ACT_WRITE)
		|| (item.action == dccpm_pkg::ACT_VERIFY);
	assign cv_ok      = (item.cv_addr != '0) && (item.cv_addr <= dccpm_pkg::CvLimit);
	assign phase_idle = (phase != dccpm_pkg::PH_PAGE) && (phase != dccpm_pkg::PH_DATA);
	assign req_ok     = cv_ok && item.common_ready && phase_idle;

	// Only the low ten bits matter once the number is known to be in range.
	assign cv_m1    = item.cv_addr[9:0] - 10'd1;
	assign page     = cv_m1[9:2] + 8'd1;
	assign page_idx = (cfg.page_register_number[2:0] - 3'd1) & dccpm_pkg::IndexMask;
	assign page_b0  = cfg.write_prefix | {5'd0, page_idx};

	assign data_prefix = latch.write_op ? cfg.write_prefix : cfg.verify_prefix;
	assign data_b0     = data_prefix | {6'd0, latch.reg_index};

	// Next phase and latched operation
	always_comb begin
		phase_next = phase;
		latch_next = latch;
		unique case (phase)
			dccpm_pkg::PH_PAGE: begin
				if (item.action == dccpm_pkg::ACT_COMPLETE) begin
					phase_next = item.common_ready ? dccpm_pkg::PH_DATA : dccpm_pkg::PH_IDLE;
				end
			end
			dccpm_pkg::PH_DATA: begin
				if (item.action == dccpm_pkg::ACT_COMPLETE) begin
					phase_next = dccpm_pkg::PH_IDLE;
				end
			end
			default: begin
				if (is_request && req_ok) begin
					phase_next          = dccpm_pkg::PH_PAGE;
					latch_next.reg_index = cv_m1[1:0];
					latch_next.value     = item.data_byte;
					latch_next.write_op  = (item.action == dccpm_pkg::ACT_WRITE);
				end
			end
		endcase
	end

	// Result word
	always_comb begin
		result = '0;
		if (is_request) begin
			result.valid = 1'b1;
			if (req_ok) begin
				result.kind          = dccpm_pkg::KIND_START;
				result.byte0         = page_b0;
				result.byte1         = page;
				result.byte2         = page_b0 ^ page;
				result.step_is_write = 1'b1;
			end else begin
				result.kind = dccpm_pkg::KIND_REFUSED;
			end
		end else if (item.action == dccpm_pkg::ACT_COMPLETE) begin
			unique case (phase)
				dccpm_pkg::PH_PAGE: begin
					result.valid = 1'b1;
					if (item.common_ready) begin
						result.kind          = dccpm_pkg::KIND_START;
						result.byte0         = data_b0;
						result.byte1         = latch.value;
						result.byte2         = data_b0 ^ latch.value;
						result.step_is_write = latch.write_op;
					end else begin
						result.kind        = dccpm_pkg::KIND_FINISHED;
						result.finish_code = cfg.busy_code;
					end
				end
				dccpm_pkg::PH_DATA: begin
					result.valid       = 1'b1;
					result.kind        = dccpm_pkg::KIND_FINISHED;
					result.finish_code = item.step_result;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/dcc_paged_mode_programming_sequencer.sv @@
// Top level of the paged-mode programming sequencer: input register, step logic, result register.
//
// Paged-mode service programming sequencer. Each request word (write or verify of a
// variable numbered 1 to 1024) first produces a register-write packet that loads the
// page register; a following step-complete word produces the data-register write or
// verify packet, and the next step-complete word finishes the operation with the
// forwarded step result. A request outside 1..1024, with the common module not ready,
// or while an operation is running is refused. A step complete in the page phase with
// the common module not ready finishes with the configured busy code. A stray step
// complete while idle and the unused action code produce no result. Throughput is one
// word per clock while no held result stalls the input side. A word is captured by the
// input register when accepted; its result is then loaded into the result register and
// offered from there. All decoding is done in the single logic stage between the two
// registers. The result register lets a new word enter while a result waits; the input
// side stalls only when both registers are full and the result is held. Configuration
// writes are always ready and must only be issued while the block is idle.
module dcc_paged_mode_programming_sequencer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [15:0] cv_addr,
	input  logic [7:0]  data_byte,
	input  logic        common_ready,
	input  logic [3:0]  step_result,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  response_kind,
	output logic [7:0]  packet_byte0,
	output logic [7:0]  packet_byte1,
	output logic [7:0]  packet_byte2,
	output logic        step_is_write,
	output logic [3:0]  finish_code
);

	dccpm_pkg::cfg_t     cfg;
	dccpm_pkg::item_t    item_s1;
	logic                valid_s1;
	dccpm_pkg::phase_t   phase_q;
	dccpm_pkg::phase_t   phase_next;
	dccpm_pkg::latch_t   latch_q;
	dccpm_pkg::latch_t   latch_next;
	dccpm_pkg::result_t  result;
	dccpm_pkg::result_t  rsp_s2;
	logic                rsp_valid_s2;
	logic                drain;

	dccpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The word in the input register moves on when the result register is free or
	// being emptied this cycle. Words with no result move on all the same.
	assign drain     = !rsp_valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !drain;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.action       <= action;
			item_s1.cv_addr      <= cv_addr;
			item_s1.data_byte    <= data_byte;
			item_s1.common_ready <= common_ready;
			item_s1.step_result  <= step_result;
		end
	end

	dccpm_step u_step (
		.item       (item_s1),
		.cfg        (cfg),
		.phase      (phase_q),
		.latch      (latch_q),
		.phase_next (phase_next),
		.latch_next (latch_next),
		.result     (result)
	);

	// Advance the operation state only when the word actually leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dccpm_pkg::PH_IDLE;
			latch_q <= '0;
		end else if (valid_s1 && drain) begin
			phase_q <= phase_next;
			latch_q <= latch_next;
		end
	end

	// Result register: hold while stalled, otherwise load or drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (drain) begin
			rsp_valid_s2 <= valid_s1 && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (drain && valid_s1 && result.valid) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid     = rsp_valid_s2;
	assign response_kind = rsp_s2.kind;
	assign packet_byte0  = rsp_s2.byte0;
	assign packet_byte1  = rsp_s2.byte1;
	assign packet_byte2  = rsp_s2.byte2;
	assign step_is_write = rsp_s2.step_is_write;
	assign finish_code   = rsp_s2.finish_code;

endmodule

@@ hdl/dccpm_checker.sv @@
// Port-level checker of the paged-mode programming sequencer, with its bind.
module dccpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [1:0] response_kind,
	input logic [7:0] packet_byte0,
	input logic [7:0] packet_byte1,
	input logic [7:0] packet_byte2,
	input logic       step_is_write,
	input logic [3:0] finish_code
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(response_kind)
			&& $stable(packet_byte0) && $stable(packet_byte1) && $stable(finish_code))
		else $error("result word changed while stalled");

	a_xor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && response_kind == dccpm_pkg::KIND_START
			|-> packet_byte2 == (packet_byte0 ^ packet_byte1) && finish_code == 4'd0)
		else $error("start packet check byte wrong");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && response_kind == dccpm_pkg::KIND_REFUSED
			|-> packet_byte0 == 8'd0 && packet_byte1 == 8'd0 && packet_byte2 == 8'd0
				&& !step_is_write && finish_code == 4'd0)
		else $error("refusal carries payload");

	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && response_kind == dccpm_pkg::KIND_FINISHED
			|-> packet_byte0 == 8'd0 && packet_byte1 == 8'd0 && !step_is_write)
		else $error("finish word carries packet");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> response_kind != 2'd3)
		else $error("undefined response kind");

endmodule

bind dcc_paged_mode_programming_sequencer dccpm_checker u_dccpm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.response_kind (response_kind),
	.packet_byte0  (packet_byte0),
	.packet_byte1  (packet_byte1),
	.packet_byte2  (packet_byte2),
	.step_is_write (step_is_write),
	.finish_code   (finish_code)
);

@@ tb/sv/dccpm_response_check.sv @@
// Response checker for the paged-mode programming sequencer: predicts every response and compares it.
module dccpm_response_check
	import dccpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  action,
	input  logic [15:0] cv_addr,
	input  logic [7:0]  data_byte,
	input  logic        common_ready,
	input  logic [3:0]  step_result,

	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  response_kind,
	input  logic [7:0]  packet_byte0,
	input  logic [7:0]  packet_byte1,
	input  logic [7:0]  packet_byte2,
	input  logic        step_is_write,
	input  logic [3:0]  finish_code,

	output int unsigned errors,
	output int unsigned outstanding,
	output int unsigned checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MaxReports = 10;

	cfg_t    settings;
	phase_t  phase;
	latch_t  held;
	result_t pending_responses[$];

	function automatic void note_failure(string msg);
		if (errors < MaxReports) $display("[%0t] %s", $time, msg);
		errors++;
	endfunction

	function automatic result_t step_packet(logic [ByteWidth-1:0] prefix, logic [2:0] idx,
			logic [ByteWidth-1:0] value, logic write_op);
		result_t r;
		r = '0;
		r.valid = 1'b1;
		r.kind = KIND_START;
		r.byte0 = prefix | {5'd0, idx};
		r.byte1 = value;
		r.byte2 = r.byte0 ^ value;
		r.step_is_write = write_op;
		return r;
	endfunction

	function automatic result_t finished(logic [CodeWidth-1:0] code);
		result_t r;
		r = '0;
		r.valid = 1'b1;
		r.kind = KIND_FINISHED;
		r.finish_code = code;
		return r;
	endfunction

	// Advance the sequencer by one word; valid is low when the word gives no response.
	function automatic result_t next_response(item_t w);
		result_t             r;
		logic [CvWidth-1:0]  cv_less;
		logic [CvWidth-1:0]  page;
		logic [RegWidth-1:0] page_idx;
		r = '0;
		cv_less = w.cv_addr - 1'b1;
		// four data registers per page: low two bits pick the register, the rest the page
		page = {2'd0, cv_less[CvWidth-1:2]} + 1'b1;
		page_idx = settings.page_register_number - 1'b1;
		case (action_t'(w.action))
		ACT_WRITE, ACT_VERIFY: begin
			r.valid = 1'b1;
			r.kind = KIND_REFUSED;
			if (w.cv_addr != '0 && w.cv_addr <= CvLimit && w.common_ready &&
					phase == PH_IDLE) begin
				held.reg_index = cv_less[1:0];
				held.value = w.data_byte;
				held.write_op = (action_t'(w.action) == ACT_WRITE);
				phase = PH_PAGE;
				r = step_packet(settings.write_prefix, page_idx[2:0] & IndexMask,
					page[ByteWidth-1:0], 1'b1);
			end
		end
		ACT_COMPLETE: begin
			if (phase == PH_PAGE) begin
				if (!w.common_ready) begin
					phase = PH_IDLE;
					r = finished(settings.busy_code);
				end else begin
					phase = PH_DATA;
					r = step_packet(held.write_op ? settings.write_prefix : settings.verify_prefix,
						{1'b0, held.reg_index}, held.value, held.write_op);
				end
			end else if (phase == PH_DATA) begin
				phase = PH_IDLE;
				r = finished(w.step_result);
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t seen;
		result_t want;
		item_t   w;
		if (!arst_n) begin
			settings = '{WritePrefixReset, VerifyPrefixReset, PageRegReset, BusyCodeReset};
			phase = PH_IDLE;
			held = '0;
			pending_responses.delete();
			errors = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				seen = '0;
				seen.kind = kind_t'(response_kind);
				seen.byte0 = packet_byte0;
				seen.byte1 = packet_byte1;
				seen.byte2 = packet_byte2;
				seen.step_is_write = step_is_write;
				seen.finish_code = finish_code;
				checked++;
				if (pending_responses.size() == 0) begin
					note_failure($sformatf("unexpected response: kind %0d b0 %h b1 %h b2 %h wr %b code %h",
						seen.kind, seen.byte0, seen.byte1, seen.byte2, seen.step_is_write,
						seen.finish_code));
				end else begin
					want = pending_responses.pop_front();
					if (seen.kind !== want.kind || seen.byte0 !== want.byte0 ||
							seen.byte1 !== want.byte1 || seen.byte2 !== want.byte2 ||
							seen.step_is_write !== want.step_is_write ||
							seen.finish_code !== want.finish_code)
						note_failure($sformatf({"response mismatch: expected kind %0d b0 %h b1 %h ",
							"b2 %h wr %b code %h, got kind %0d b0 %h b1 %h b2 %h wr %b code %h"},
							want.kind, want.byte0, want.byte1, want.byte2, want.step_is_write,
							want.finish_code, seen.kind, seen.byte0, seen.byte1, seen.byte2,
							seen.step_is_write, seen.finish_code));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
				CFG_WRITE_PREFIX:  settings.write_prefix = cfg_data;
				CFG_VERIFY_PREFIX: settings.verify_prefix = cfg_data;
				CFG_PAGE_REG:      settings.page_register_number = cfg_data[RegWidth-1:0];
				CFG_BUSY_CODE:     settings.busy_code = cfg_data[CodeWidth-1:0];
				default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				w = '{action, cv_addr, data_byte, common_ready, step_result};
				want = next_response(w);
				if (want.valid) pending_responses.push_back(want);
			end
			outstanding = pending_responses.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the paged-mode sequencer testbench: clock, reset, word stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dccpm_pkg::*;

	localparam int unsigned ResetCycles = 7;
	localparam int unsigned RandomWords = 1000;
	localparam int unsigned Segments    = 5;
	localparam int unsigned HoldCycles  = 200;
	// drain time for the input and result registers of the block, plus margin
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned CycleLimit  = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  action;
	logic [15:0] cv_addr;
	logic [7:0]  data_byte;
	logic        common_ready;
	logic [3:0]  step_result;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  response_kind;
	logic [7:0]  packet_byte0;
	logic [7:0]  packet_byte1;
	logic [7:0]  packet_byte2;
	logic        step_is_write;
	logic [3:0]  finish_code;

	int unsigned errors;
	int unsigned outstanding;
	int unsigned checked;

	// flags shared between the sender and the receiver, and the sender's counts
	bit          no_idle;
	bit          hold_off_req;
	int unsigned words_sent;
	int unsigned settings_used;

	dcc_paged_mode_programming_sequencer i_dut (.*);

	dccpm_response_check i_check (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	initial begin : receiver
		int unsigned held_for;
		rsp_stall = 1'b0;
		held_for = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rsp_stall <= 1'b1;
				held_for++;
				if (held_for == HoldCycles) begin
					hold_off_req = 1'b0;
					held_for = 0;
				end
			end else
				rsp_stall <= !no_idle && ($urandom_range(99) < 26);
		end
	end

	// Watchdog: a correct run ends far inside this limit.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("** dcc_paged_mode_programming_sequencer: FAILED **");
		$finish;
	end

	function automatic item_t word(action_t act, int unsigned cv, int unsigned dv,
			bit ready, int unsigned res);
		item_t w;
		w.action = act;
		w.cv_addr = cv[15:0];
		w.data_byte = dv[7:0];
		w.common_ready = ready;
		w.step_result = res[3:0];
		return w;
	endfunction

	// Legal words carry an in-range variable and a mostly ready common module; the rest
	// is noise over the whole field range and around the range edges.
	function automatic item_t random_word(action_t act, bit legal);
		int unsigned cv;
		if (legal)
			cv = $urandom_range(int'(CvLimit), 1);
		else if ($urandom_range(1))
			cv = $urandom_range(16'hFFFF, 0);
		else
			cv = $urandom_range(int'(CvLimit) + 6, 0);
		return word(act, cv, $urandom_range(255),
			legal ? ($urandom_range(19) != 0) : 1'($urandom_range(1)), $urandom_range(15));
	endfunction

	// Offer one word, idling first at random, and hold it until it is taken.
	task automatic offer_word(item_t w);
		while (!no_idle && $urandom_range(99) < 26) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= w.action;
		cv_addr <= w.cv_addr;
		data_byte <= w.data_byte;
		common_ready <= w.common_ready;
		step_result <= w.step_result;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (action_t'(w.action) != ACT_UNUSED) words_sent++;
	endtask

	// Drop valid and wait until every expected response has come, then let the pipe drain.
	task automatic quiesce();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes never lower and raise it in one step.
	task automatic write_register(cfg_index_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_settings(cfg_t c);
		write_register(CFG_WRITE_PREFIX, c.write_prefix);
		write_register(CFG_VERIFY_PREFIX, c.verify_prefix);
		write_register(CFG_PAGE_REG, {4'd0, c.page_register_number});
		write_register(CFG_BUSY_CODE, {4'd0, c.busy_code});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly complete operations (request, page done, data done) with random content,
	// the rest single noise words.
	task automatic random_operation();
		if ($urandom_range(99) < 75) begin
			offer_word(random_word($urandom_range(1) ? ACT_VERIFY : ACT_WRITE, 1'b1));
			offer_word(random_word(ACT_COMPLETE, 1'b1));
			offer_word(random_word(ACT_COMPLETE, 1'b1));
		end else
			offer_word(random_word(action_t'($urandom_range(3)), 1'b0));
	endtask

	initial begin : stimulus
		cfg_t        plan[Segments];
		int unsigned target;
		bit          paused;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		action = '0;
		cv_addr = '0;
		data_byte = '0;
		common_ready = 1'b0;
		step_result = '0;
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		words_sent = 0;
		settings_used = 1;
		paused = 1'b0;

		// extremes first: page register 0 wraps the index, prefixes with low bits set
		plan[0] = '{8'hFF, 8'h00, 4'd0, 4'd15};
		plan[1] = '{8'h00, 8'hFF, 4'd8, 4'd0};
		plan[2] = '{8'h7B, 8'h75, 4'd1, 4'd7};
		plan[3] = '{8'($urandom_range(255)), 8'($urandom_range(255)),
			4'($urandom_range(15)), 4'($urandom_range(15))};
		plan[4] = '{WritePrefixReset, VerifyPrefixReset, 4'd15, BusyCodeReset};

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings.
		offer_word(word(ACT_WRITE, 1, 8'h00, 1'b1, 0));          // page 1
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 0));           // data write
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 15));          // finish, top code
		offer_word(word(ACT_VERIFY, 1024, 8'hFF, 1'b1, 0));      // page 256 wraps to 0
		offer_word(word(ACT_WRITE, 2, 8'h11, 1'b1, 0));          // refused, page step running
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 3));           // verify step, page result ignored
		offer_word(word(ACT_VERIFY, 3, 8'h22, 1'b1, 0));         // refused, data step running
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b0, 0));           // finish, ready ignored here
		offer_word(word(ACT_WRITE, 0, 8'h33, 1'b1, 0));          // below range
		offer_word(word(ACT_WRITE, 1025, 8'h44, 1'b1, 0));       // above range
		offer_word(word(ACT_VERIFY, 16'hFFFF, 8'hFF, 1'b1, 15)); // top of the field
		offer_word(word(ACT_WRITE, 5, 8'h55, 1'b0, 0));          // common module busy
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 7));           // stray completion while idle
		offer_word(word(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 15)); // unused action
		offer_word(word(ACT_WRITE, 1021, 8'hA5, 1'b1, 0));       // page 256 again
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b0, 0));           // data step refused: busy code
		offer_word(word(ACT_VERIFY, 512, 8'h5A, 1'b1, 0));
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 0));
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 9));
		offer_word(word(ACT_WRITE, 1022, 8'h3C, 1'b1, 0));
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 0));
		offer_word(word(ACT_COMPLETE, 0, 0, 1'b1, 6));
		quiesce();

		// Random part: one register setting per segment, written only once idle.
		for (int s = 0; s < Segments; s++) begin
			load_settings(plan[s]);
			// hold idling off on both sides for the whole of the second segment
			no_idle = (s == 1);
			// stop the receiver and keep offering words, so the block fills and stalls
			if (s == 2) hold_off_req = 1'b1;
			target = words_sent + RandomWords / Segments;
			while (words_sent < target) begin
				// halfway through the fourth segment, pause until every response is in
				if (s == 3 && !paused && words_sent + RandomWords / (2 * Segments) >= target) begin
					quiesce();
					paused = 1'b1;
				end
				random_operation();
			end
			quiesce();
		end
		no_idle = 1'b0;

		$display("Run: %0d request words over %0d register settings, %0d responses checked.",
			words_sent, settings_used, checked);
		$display("Included one %0d-cycle receiver hold-off, a sender pause and an idle-free stretch.",
			HoldCycles);
		if (errors == 0 && outstanding == 0)
			$display("** dcc_paged_mode_programming_sequencer: PASSED **");
		else
			$display("** dcc_paged_mode_programming_sequencer: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/dccpm_pkg.sv
hdl/dccpm_cfg_regs.sv
hdl/dccpm_step.sv
hdl/dcc_paged_mode_programming_sequencer.sv
hdl/dccpm_checker.sv
tb/sv/dccpm_response_check.sv
tb/sv/testbench.sv
